/* hw/rtl/rbh_pkg.sv */
package rbh_pkg;

  localparam int MAX_BIT_WIDTH = 32;
  localparam int MAX_OUT       = 8;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PACKED = 2'd1,
    PH_RUN    = 2'd2
  } phase_t;

  typedef enum logic {
    CFG_WIDTH     = 1'b0,
    CFG_DEF_LEVEL = 1'b1
  } cfg_reg_t;

endpackage

/* hw/rtl/rle_bitpacked_hybrid_decoder_top.sv */
// Decoder for the RLE / bit-packed hybrid stream of a columnar page format.
// Input channel in_*: one encoded stream byte per word; in_tuser starts a new
// page and clears the decoder state before that byte is decoded.
// Output channel out_*: one decoded value per word. A packed group gives one
// word per value (run_length 1); a run group gives a single word carrying the
// run value and its length. A header that runs past five bytes gives one word
// with header_error set. out_tlast marks the last word caused by an input byte.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr
// (0 value width, 1 defined level); write only while the block is idle.
// Latency: the first word of a byte appears the cycle after the byte is taken.
// Throughput: a byte is decoded in a single pass into a bank of up to eight
// result registers, which drain one word per cycle while the receiver takes
// them. Bytes are taken at one per cycle while each yields at most one word
// and the receiver does not stall. A byte that yields words holds the input
// until its last word is taken; at a value width of 1 a byte yields up to
// eight. The next byte is taken in the same cycle as the last pending word.
// Reset (rst_n low, synchronous): decoder back to reading a group header,
// value width and defined level set to 1, no pending words.
// When the receiver stalls, the pending word holds and in_tready stays low
// until the last pending word is taken.
module rle_bitpacked_hybrid_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // new_page
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // decoded_value[31:0], run_length[62:32], zero pad
  output logic [2:0]  out_tuser,  // is_run, valid, header_error
  output logic        out_tlast,  // last_of_byte
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  // configuration
  logic [5:0]  vwidth_r;
  logic [15:0] def_lvl_r;

  // decoder state
  rbh_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] hdr_acc_r, hdr_acc_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [33:0] values_left_r, values_left_nxt;
  logic [38:0] bit_buf_r, bit_buf_nxt;
  logic [5:0]  bits_held_r, bits_held_nxt;
  logic [31:0] run_acc_r, run_acc_nxt;
  logic [2:0]  vbytes_left_r, vbytes_left_nxt;

  // result bank
  logic [31:0] bank_r [rbh_pkg::MAX_OUT];
  logic [30:0] len_r;
  logic        run_r;
  logic        err_r;
  logic [3:0]  rem_r;
  logic [2:0]  head_r;

  // state seen by this byte after new_page
  rbh_pkg::phase_t cur_phase;
  logic [31:0] cur_hacc;
  logic [2:0]  cur_hcnt;
  logic [33:0] cur_vl;
  logic [38:0] cur_buf;
  logic [5:0]  cur_held;
  logic [31:0] cur_racc;
  logic [2:0]  cur_vbl;

  logic [7:0]  b;
  logic [5:0]  ew;
  logic [5:0]  ew_plus;
  logic [2:0]  nbytes;
  logic        acc;
  logic        pop;

  // packed path
  logic [38:0] buf_in;
  logic [5:0]  held_in;
  logic [rbh_pkg::MAX_OUT-1:0] fit;
  logic [3:0]  n_pk;
  logic [8:0]  consumed;
  logic [38:0] buf_sh;
  logic [5:0]  held_sh;
  logic [33:0] vl_sub;
  logic [32:0] mask33;
  logic [38:0] pk_sh [rbh_pkg::MAX_OUT];
  logic [31:0] pk_val [rbh_pkg::MAX_OUT];

  // header path
  logic [2:0]  hdr_cnt_eff;
  logic [5:0]  hdr_shift;
  logic [38:0] hdr_piece;
  logic [31:0] hdr_new;

  // run path
  logic [2:0]  left_eff;
  logic [2:0]  left_dec;
  logic [1:0]  lane;
  logic [31:0] run_new;

  // results of this byte
  logic [3:0]  res_n;
  logic [31:0] res_val [rbh_pkg::MAX_OUT];
  logic [30:0] res_len;
  logic        res_run;
  logic        res_err;

  assign b   = in_tdata;
  assign acc = in_tvalid && in_tready;
  assign pop = out_tvalid && out_tready;

  assign in_tready = (rem_r == 4'd0) || ((rem_r == 4'd1) && out_tready);

  always_comb begin : eff_width
    if (vwidth_r == 6'd0) begin
      ew = 6'd1;
    end else if (vwidth_r > 6'(rbh_pkg::MAX_BIT_WIDTH)) begin
      ew = 6'(rbh_pkg::MAX_BIT_WIDTH);
    end else begin
      ew = vwidth_r;
    end
  end

  assign ew_plus = ew + 6'd7;
  assign nbytes  = ew_plus[5:3];

  always_comb begin : page_clear
    if (in_tuser) begin
      cur_phase = rbh_pkg::PH_HEADER;
      cur_hacc  = '0;
      cur_hcnt  = '0;
      cur_vl    = '0;
      cur_buf   = '0;
      cur_held  = '0;
      cur_racc  = '0;
      cur_vbl   = '0;
    end else begin
      cur_phase = phase_r;
      cur_hacc  = hdr_acc_r;
      cur_hcnt  = hdr_cnt_r;
      cur_vl    = values_left_r;
      cur_buf   = bit_buf_r;
      cur_held  = bits_held_r;
      cur_racc  = run_acc_r;
      cur_vbl   = vbytes_left_r;
    end
  end

  // packed values
  assign buf_in  = cur_buf | ({31'b0, b} << cur_held);
  assign held_in = cur_held + 6'd8;
  assign mask33  = (33'd1 << ew) - 33'd1;

  always_comb begin : pk_count
    n_pk = '0;
    for (int k = 0; k < rbh_pkg::MAX_OUT; k++) begin
      fit[k] = ({3'b000, held_in} >= 9'(k + 1) * {3'b000, ew}) && (cur_vl > 34'(k));
      n_pk   = n_pk + 4'(fit[k]);
    end
  end

  always_comb begin : pk_extract
    for (int k = 0; k < rbh_pkg::MAX_OUT; k++) begin
      pk_sh[k]  = buf_in >> (9'(k) * {3'b000, ew});
      pk_val[k] = pk_sh[k][31:0] & mask33[31:0];
    end
  end

  assign consumed = {5'b0, n_pk} * {3'b000, ew};
  assign buf_sh   = buf_in >> consumed;
  assign held_sh  = held_in - consumed[5:0];
  assign vl_sub   = cur_vl - {30'b0, n_pk};

  // header byte
  assign hdr_cnt_eff = (cur_hcnt > 3'd4) ? 3'd4 : cur_hcnt;
  assign hdr_shift   = {3'b000, hdr_cnt_eff} * 6'd7;
  assign hdr_piece   = {32'b0, b[6:0]} << hdr_shift;
  assign hdr_new     = cur_hacc | hdr_piece[31:0];

  // run value byte
  assign left_eff = (cur_vbl == 3'd0) ? 3'd1 : cur_vbl;
  assign left_dec = left_eff - 3'd1;
  assign lane     = 2'(nbytes - left_eff);
  assign run_new  = cur_racc | ({24'b0, b} << {lane, 3'b000});

  always_comb begin : next_state
    phase_nxt       = cur_phase;
    hdr_acc_nxt     = cur_hacc;
    hdr_cnt_nxt     = cur_hcnt;
    values_left_nxt = cur_vl;
    bit_buf_nxt     = cur_buf;
    bits_held_nxt   = cur_held;
    run_acc_nxt     = cur_racc;
    vbytes_left_nxt = cur_vbl;
    case (cur_phase)
      rbh_pkg::PH_PACKED: begin
        values_left_nxt = vl_sub;
        if (vl_sub == 34'd0) begin
          bit_buf_nxt   = '0;
          bits_held_nxt = '0;
          phase_nxt     = rbh_pkg::PH_HEADER;
        end else if (held_sh > 6'd31) begin
          bit_buf_nxt   = {8'b0, buf_sh[30:0]};
          bits_held_nxt = 6'd31;
        end else begin
          bit_buf_nxt   = buf_sh;
          bits_held_nxt = held_sh;
        end
      end
      rbh_pkg::PH_RUN: begin
        vbytes_left_nxt = left_dec;
        run_acc_nxt     = run_new;
        if (left_dec == 3'd0) begin
          values_left_nxt = '0;
          run_acc_nxt     = '0;
          phase_nxt       = rbh_pkg::PH_HEADER;
        end
      end
      default: begin
        phase_nxt   = rbh_pkg::PH_HEADER;
        hdr_acc_nxt = hdr_new;
        if (b[7]) begin
          if (hdr_cnt_eff == 3'd4) begin
            hdr_acc_nxt = '0;
            hdr_cnt_nxt = '0;
          end else begin
            hdr_cnt_nxt = hdr_cnt_eff + 3'd1;
          end
        end else begin
          hdr_acc_nxt = '0;
          hdr_cnt_nxt = '0;
          if (hdr_new[0]) begin
            values_left_nxt = {hdr_new[31:1], 3'b000};
            bit_buf_nxt     = '0;
            bits_held_nxt   = '0;
            phase_nxt       = (hdr_new[31:1] != 31'd0) ? rbh_pkg::PH_PACKED
                                                       : rbh_pkg::PH_HEADER;
          end else begin
            values_left_nxt = {3'b000, hdr_new[31:1]};
            run_acc_nxt     = '0;
            vbytes_left_nxt = nbytes;
            phase_nxt       = rbh_pkg::PH_RUN;
          end
        end
      end
    endcase
  end

  always_comb begin : results
    res_n   = '0;
    res_len = '0;
    res_run = 1'b0;
    res_err = 1'b0;
    for (int k = 0; k < rbh_pkg::MAX_OUT; k++) begin
      res_val[k] = pk_val[k];
    end
    case (cur_phase)
      rbh_pkg::PH_PACKED: begin
        res_n   = n_pk;
        res_len = 31'd1;
      end
      rbh_pkg::PH_RUN: begin
        if ((left_dec == 3'd0) && (cur_vl != 34'd0)) begin
          res_n      = 4'd1;
          res_val[0] = run_new;
          res_len    = cur_vl[30:0];
          res_run    = 1'b1;
        end
      end
      default: begin
        if (b[7] && (hdr_cnt_eff == 3'd4)) begin
          res_n      = 4'd1;
          res_val[0] = '0;
          res_err    = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vwidth_r        <= 6'd1;
      def_lvl_r       <= 16'd1;
      phase_r         <= rbh_pkg::PH_HEADER;
      hdr_acc_r       <= '0;
      hdr_cnt_r       <= '0;
      values_left_r   <= '0;
      bit_buf_r       <= '0;
      bits_held_r     <= '0;
      run_acc_r       <= '0;
      vbytes_left_r   <= '0;
      rem_r           <= '0;
      head_r          <= '0;
    end else begin
      if (cfg_we) begin
        case (rbh_pkg::cfg_reg_t'(cfg_addr))
          rbh_pkg::CFG_WIDTH:     vwidth_r  <= cfg_wdata[5:0];
          rbh_pkg::CFG_DEF_LEVEL: def_lvl_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (acc) begin
        phase_r       <= phase_nxt;
        hdr_acc_r     <= hdr_acc_nxt;
        hdr_cnt_r     <= hdr_cnt_nxt;
        values_left_r <= values_left_nxt;
        bit_buf_r     <= bit_buf_nxt;
        bits_held_r   <= bits_held_nxt;
        run_acc_r     <= run_acc_nxt;
        vbytes_left_r <= vbytes_left_nxt;
        rem_r         <= res_n;
        head_r        <= '0;
      end else if (pop) begin
        rem_r  <= rem_r - 4'd1;
        head_r <= head_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int k = 0; k < rbh_pkg::MAX_OUT; k++) begin
        bank_r[k] <= res_val[k];
      end
      len_r <= res_len;
      run_r <= res_run;
      err_r <= res_err;
    end
  end

  assign out_tvalid = (rem_r != 4'd0);
  assign out_tlast  = (rem_r == 4'd1);
  assign out_tdata  = {1'b0, len_r, bank_r[head_r]};
  assign out_tuser  = {err_r, (!err_r && (bank_r[head_r] == {16'b0, def_lvl_r})), run_r};

  // checks
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 4'(rbh_pkg::MAX_OUT))
    else $error("result bank count out of range");

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bits_held_r <= 6'd31)
    else $error("bit buffer holds too many bits");

  a_header_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rbh_pkg::PH_HEADER |-> bits_held_r == 6'd0)
    else $error("stale packed bits while reading a header");

  a_head_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !acc && (rem_r > 4'd1) |=> head_r == $past(head_r) + 3'd1)
    else $error("bank read pointer did not advance");

  a_hdr_err: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (cur_phase == rbh_pkg::PH_HEADER) && b[7] && (hdr_cnt_eff == 3'd4)
    |=> out_tvalid && out_tuser[2] && out_tlast)
    else $error("overlong header gave no error word");

endmodule

/* sim/rle_bitpacked_hybrid_decoder_top_tb.sv */
module rle_bitpacked_hybrid_decoder_top_tb;

  typedef struct packed {
    logic [31:0] value;
    logic [30:0] run_len;
    logic        is_run;
    logic        def_ok;
    logic        hdr_err;
    logic        last;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;   // data_byte
  logic        in_tuser = 1'b0;   // new_page
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;         // decoded_value, run_length, zero pad
  logic [2:0]  out_tuser;         // is_run, valid, header_error
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  rbh_pkg::cfg_reg_t cfg_addr = rbh_pkg::CFG_WIDTH;
  logic [15:0] cfg_wdata = 16'd0;

  rle_bitpacked_hybrid_decoder_top uut (.*);

  // register copies
  logic [5:0]  width_reg = 6'd1;
  logic [15:0] def_level = 16'd1;

  // decoder state copy
  rbh_pkg::phase_t dec_phase = rbh_pkg::PH_HEADER;
  logic [31:0] hdr_acc = '0;
  logic [2:0]  hdr_cnt = '0;
  logic [63:0] vals_left = '0;
  logic [63:0] bitbuf = '0;
  int unsigned nbits = 0;
  logic [31:0] run_acc = '0;
  logic [2:0]  run_bytes_left = '0;

  word_t       pending_words[$];
  logic [7:0]  tx_bytes[$];

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int hold_cycles = 0;
  int mismatches = 0;
  int n_bytes = 0;
  int n_words = 0;
  int n_runs = 0;
  int n_errs = 0;
  int n_valid = 0;
  int n_writes = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic int unsigned active_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > rbh_pkg::MAX_BIT_WIDTH) w = rbh_pkg::MAX_BIT_WIDTH;
    return w;
  endfunction

  function automatic void clear_decoder();
    dec_phase = rbh_pkg::PH_HEADER;
    hdr_acc = '0;
    hdr_cnt = '0;
    vals_left = '0;
    bitbuf = '0;
    nbits = 0;
    run_acc = '0;
    run_bytes_left = '0;
  endfunction

  function automatic word_t make_word(input logic [31:0] v, input logic [30:0] len,
                                      input logic run, input logic err);
    word_t wd;
    wd.value = v;
    wd.run_len = len;
    wd.is_run = run;
    wd.hdr_err = err;
    wd.def_ok = !err && (v == {16'd0, def_level});
    wd.last = 1'b0;
    return wd;
  endfunction

  // expected words caused by one accepted stream byte
  function automatic void decode_byte(input logic [7:0] b, input logic np);
    int unsigned w, nb, left, lane, cnt;
    logic [31:0] v, ind, sh;
    word_t outs[$];
    word_t wd;
    w = active_width();
    if (np) clear_decoder();
    case (dec_phase)
      rbh_pkg::PH_PACKED: begin
        bitbuf = bitbuf | (64'(b) << nbits);
        nbits += 8;
        while (outs.size() < rbh_pkg::MAX_OUT && vals_left > 0 && nbits >= w) begin
          v = 32'(bitbuf & ((64'd1 << w) - 64'd1));
          bitbuf = bitbuf >> w;
          nbits -= w;
          vals_left = vals_left - 1;
          outs = {outs, make_word(v, 31'd1, 1'b0, 1'b0)};
        end
        if (vals_left == 0) begin
          bitbuf = '0;
          nbits = 0;
          dec_phase = rbh_pkg::PH_HEADER;
        end else if (nbits > 31) begin
          bitbuf = bitbuf & 64'h7FFF_FFFF;
          nbits = 31;
        end
      end
      rbh_pkg::PH_RUN: begin
        nb = (w + 7) / 8;
        left = run_bytes_left;
        if (left == 0) left = 1;
        lane = (nb - left) & 3;
        run_acc = run_acc | (32'(b) << (8 * lane));
        left--;
        run_bytes_left = 3'(left);
        if (left == 0) begin
          if (vals_left > 0) begin
            outs = {outs, make_word(run_acc, vals_left[30:0], 1'b1, 1'b0)};
          end
          vals_left = '0;
          run_acc = '0;
          dec_phase = rbh_pkg::PH_HEADER;
        end
      end
      default: begin
        cnt = hdr_cnt;
        if (cnt > 4) cnt = 4;
        sh = 32'(b[6:0]);
        sh = sh << (7 * cnt);
        hdr_acc = hdr_acc | sh;
        if (b[7]) begin
          if (cnt == 4) begin
            outs = {outs, make_word(32'd0, 31'd0, 1'b0, 1'b1)};
            hdr_acc = '0;
            hdr_cnt = '0;
          end else begin
            hdr_cnt = 3'(cnt + 1);
          end
        end else begin
          ind = hdr_acc;
          hdr_acc = '0;
          hdr_cnt = '0;
          if (ind[0]) begin
            vals_left = 64'(ind >> 1) * 64'd8;
            bitbuf = '0;
            nbits = 0;
            dec_phase = (vals_left > 0) ? rbh_pkg::PH_PACKED : rbh_pkg::PH_HEADER;
          end else begin
            vals_left = 64'(ind >> 1);
            run_acc = '0;
            run_bytes_left = 3'((w + 7) / 8);
            dec_phase = rbh_pkg::PH_RUN;
          end
        end
      end
    endcase
    for (int k = 0; k < outs.size(); k++) begin
      wd = outs[k];
      wd.last = (k == outs.size() - 1);
      pending_words = {pending_words, wd};
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic np);
    @(negedge clk);
    if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= np;
    do @(posedge clk); while (in_tready !== 1'b1);
    decode_byte(b, np);
    n_bytes++;
  endtask

  task automatic flush_bytes(input logic np);
    for (int i = 0; i < tx_bytes.size(); i++) begin
      send_byte(tx_bytes[i], (i == 0) ? np : 1'b0);
    end
    tx_bytes.delete();
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input rbh_pkg::cfg_reg_t idx, input logic [15:0] val);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == rbh_pkg::CFG_WIDTH) width_reg = val[5:0];
    else def_level = val;
    n_writes++;
  endtask

  task automatic push_varint(input logic [31:0] v);
    logic [7:0] byte_v;
    do begin
      byte_v = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) byte_v[7] = 1'b1;
      tx_bytes = {tx_bytes, byte_v};
    end while (v != 0);
    // non-minimal encoding now and then
    if (tx_bytes.size() < 5 && $urandom_range(0, 7) == 0) begin
      byte_v = tx_bytes.pop_back();
      tx_bytes = {tx_bytes, 8'(byte_v | 8'h80), 8'h00};
    end
  endtask

  // receiver: random stall bursts plus a long hold when asked
  initial begin : sink_ctrl
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else if (sink_idle_pct != 0 && $urandom_range(1, 100) <= sink_idle_pct) begin
        out_tready <= 1'b0;
        stall = $urandom_range(0, 10);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : word_check
    word_t got;
    word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[31:0], out_tdata[62:32], out_tuser[0], out_tuser[1], out_tuser[2],
             out_tlast};
      if (pending_words.size() == 0) begin
        flag_error($sformatf("unexpected word: val=%h len=%h run=%b ok=%b err=%b last=%b",
                             got.value, got.run_len, got.is_run, got.def_ok, got.hdr_err,
                             got.last));
      end else begin
        want = pending_words.pop_front();
        n_words++;
        if (want.is_run) n_runs++;
        if (want.hdr_err) n_errs++;
        if (want.def_ok) n_valid++;
        if (got !== want) begin
          flag_error({
            $sformatf("mismatch: exp val=%h len=%h run=%b ok=%b err=%b last=%b",
                      want.value, want.run_len, want.is_run, want.def_ok, want.hdr_err,
                      want.last),
            $sformatf(", got val=%h len=%h run=%b ok=%b err=%b last=%b",
                      got.value, got.run_len, got.is_run, got.def_ok, got.hdr_err,
                      got.last)});
        end
      end
    end
  end

  task automatic test_reset_config();
    tx_bytes = '{8'h03, 8'hA5};
    flush_bytes(1'b0);
    tx_bytes = '{8'h0A, 8'h01};
    flush_bytes(1'b0);
  endtask

  task automatic test_header_limits();
    // overlong header, then a five byte header with the top count
    tx_bytes = '{8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    flush_bytes(1'b0);
    tx_bytes = '{8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h00};
    flush_bytes(1'b0);
  endtask

  task automatic test_empty_groups();
    tx_bytes = '{8'h01, 8'h00, 8'h55};
    flush_bytes(1'b0);
  endtask

  task automatic test_width_zero_new_page();
    write_reg(rbh_pkg::CFG_WIDTH, 16'hFFC0);
    write_reg(rbh_pkg::CFG_DEF_LEVEL, 16'h0000);
    tx_bytes = '{8'h03};
    flush_bytes(1'b0);
    // new page in the middle of a packed group
    tx_bytes = '{8'h02, 8'h00};
    flush_bytes(1'b1);
  endtask

  task automatic test_width_change();
    write_reg(rbh_pkg::CFG_WIDTH, 16'd16);
    write_reg(rbh_pkg::CFG_DEF_LEVEL, 16'hFFFF);
    tx_bytes = '{8'h06, 8'hFF};
    flush_bytes(1'b0);
    // wider than the maximum, mid run value
    write_reg(rbh_pkg::CFG_WIDTH, 16'h003F);
    tx_bytes = '{8'hFF};
    flush_bytes(1'b0);
    tx_bytes = '{8'h02, 8'hFF, 8'hFF, 8'h00, 8'h00};
    flush_bytes(1'b0);
  endtask

  task automatic test_backpressure();
    write_reg(rbh_pkg::CFG_WIDTH, 16'd1);
    src_idle_pct = 0;
    sink_idle_pct = 0;
    hold_cycles = 200;
    for (int g = 0; g < 4; g++) begin
      tx_bytes = {tx_bytes, 8'h05};
      tx_bytes = {tx_bytes, 8'($urandom_range(0, 255))};
      tx_bytes = {tx_bytes, 8'($urandom_range(0, 255))};
      flush_bytes(1'b0);
    end
    wait_drained();
  endtask

  task automatic send_random_stream(input int count);
    int sent, pick, groups, cap, k;
    int unsigned w, nb;
    logic [31:0] rv, cnt;
    logic restart, cut;
    sent = 0;
    restart = 1'($urandom_range(0, 1));
    while (sent < count) begin
      w = active_width();
      pick = $urandom_range(0, 99);
      cut = 1'b0;
      if (pick < 40) begin
        cap = 24 / w;
        if (cap < 1) cap = 1;
        groups = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, cap);
        push_varint(32'(groups) * 2 + 1);
        for (k = 0; k < groups * w; k++) begin
          tx_bytes = {tx_bytes, 8'($urandom_range(0, 255))};
        end
      end else if (pick < 78) begin
        k = $urandom_range(0, 9);
        if (k == 0) cnt = 0;
        else if (k == 1) cnt = $urandom >> 1;
        else cnt = $urandom_range(1, 40);
        push_varint(cnt << 1);
        rv = ($urandom_range(0, 2) == 0) ? {16'd0, def_level} : $urandom;
        nb = (w + 7) / 8;
        for (k = 0; k < nb; k++) tx_bytes = {tx_bytes, rv[8*k +: 8]};
      end else if (pick < 86) begin
        for (k = 0; k < 5; k++) tx_bytes = {tx_bytes, 8'($urandom_range(128, 255))};
      end else begin
        k = $urandom_range(1, 3);
        repeat (k) tx_bytes = {tx_bytes, 8'($urandom_range(0, 255))};
      end
      if (pick < 78 && tx_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
        k = $urandom_range(1, tx_bytes.size() - 1);
        while (tx_bytes.size() > k) void'(tx_bytes.pop_back());
        cut = 1'b1;
      end
      sent += tx_bytes.size();
      flush_bytes(restart);
      restart = cut || ($urandom_range(0, 15) == 0);
    end
  endtask

  task automatic test_random_streams();
    logic [15:0] wv, dv;
    for (int ph = 0; ph < 6; ph++) begin
      k_pick_width: begin
        case ($urandom_range(0, 9))
          0: wv = {10'($urandom), 6'd0};
          1: wv = {10'($urandom), 6'($urandom_range(33, 63))};
          2, 3, 4: wv = 16'($urandom_range(1, 8));
          default: wv = 16'($urandom_range(1, 32));
        endcase
      end
      if (ph == 0) wv = 16'd32;
      if (ph == 1) wv = 16'd1;
      dv = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      write_reg(rbh_pkg::CFG_WIDTH, wv);
      write_reg(rbh_pkg::CFG_DEF_LEVEL, dv);
      if (ph == 5) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end else begin
        src_idle_pct = $urandom_range(0, 30);
        sink_idle_pct = $urandom_range(0, 30);
      end
      send_random_stream(32);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    src_idle_pct = 20;
    sink_idle_pct = 20;
    test_reset_config();
    test_header_limits();
    test_empty_groups();
    test_width_zero_new_page();
    test_width_change();
    test_backpressure();
    test_random_streams();
    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_words.size() != 0) begin
      flag_error($sformatf("%0d expected words never arrived", pending_words.size()));
    end
    $display("covered %0d stream bytes and %0d register writes, %0d words checked",
             n_bytes, n_writes, n_words);
    $display("%0d run words, %0d header errors, %0d words flagged valid, %0d mismatches",
             n_runs, n_errs, n_valid, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
